// ----- hw/rtl/tgq_pkg.sv -----
// Package for the team grouped queue: sizes, codes and request/result structs.
// Used by every module in hw/rtl; depends on nothing.
package tgq_pkg;
  localparam int IdW   = 10;
  localparam int TeamW = 8;
  localparam int SlotW = 10;
  localparam int IdSpace   = 1 << IdW;
  localparam int TeamCount = 1 << TeamW;
  localparam int Capacity  = 1 << SlotW;

  typedef enum logic [1:0] {
    KIND_BIND = 2'd0,
    KIND_ENQ  = 2'd1,
    KIND_DEQ  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_ELEM  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IdW-1:0]   element_id;
    logic [TeamW-1:0] team;
  } request_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [IdW-1:0] element_id_out;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture request
    logic clear;    // clear one membership entry
    logic rd1;      // first read phase
    logic rd2;      // second read phase
    logic rd3;      // third read phase
    logic commit;   // write back and emit
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;
  } stat_t;
endpackage

// ----- hw/rtl/team_grouped_queue.sv -----
// Top level of the team grouped queue.
// Depends on tgq_pkg, tgq_ctrl and tgq_datapath.

// A request (bind, enqueue or dequeue) is taken when start is high and busy
// is low; its single result appears on result with done high for exactly one
// cycle, and the receiver cannot stall it. One request is in flight at a
// time: a new one is not taken until the last reaches its write-back, after
// the chain of dependent memory reads (team membership or team order, then
// the team pointers, then the head slot's value and link). After reset, busy
// stays high while the membership table is cleared to team 0.
module team_grouped_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tgq_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output tgq_pkg::result_t  result
);
  tgq_pkg::cmd_t  cmd;
  tgq_pkg::stat_t stat;

  tgq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
  );

  tgq_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .request(request), .stat(stat),
    .done(done), .result(result)
  );
endmodule

// ----- hw/rtl/tgq_ctrl.sv -----
// Controller state machine of the team grouped queue.
// Depends on tgq_pkg.
module tgq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  tgq_pkg::stat_t stat,
  output tgq_pkg::cmd_t  cmd,
  output logic           busy
);
  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_RD1    = 6'b000100,
    S_RD2    = 6'b001000,
    S_RD3    = 6'b010000,
    S_COMMIT = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = start;
        if (start) state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd1 = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd2 = 1'b1;
        state_next = S_RD3;
      end
      S_RD3: begin
        cmd.rd3 = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_commit_after_rd3: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> $past(cmd.rd3)) else $error("commit without rd3");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.rd1) else $error("load not followed by rd1");
endmodule

// ----- hw/rtl/tgq_datapath.sv -----
// Datapath of the team grouped queue: memories, pointers and result register.
// Depends on tgq_pkg.
module tgq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  tgq_pkg::cmd_t      cmd,
  input  tgq_pkg::request_t  request,
  output tgq_pkg::stat_t     stat,
  output logic               done,
  output tgq_pkg::result_t   result
);
  localparam int IdW = tgq_pkg::IdW;
  localparam int TeamW = tgq_pkg::TeamW;
  localparam int SlotW = tgq_pkg::SlotW;

  // Memories. Membership is cleared by a pass after reset.
  logic [TeamW-1:0] team_of_element [tgq_pkg::IdSpace];
  logic [IdW-1:0]   slot_value [tgq_pkg::Capacity];
  logic [SlotW-1:0] slot_next [tgq_pkg::Capacity];
  logic [SlotW-1:0] free_slots [tgq_pkg::Capacity];
  logic [SlotW-1:0] team_head_slot [tgq_pkg::TeamCount];
  logic [SlotW-1:0] team_tail_slot [tgq_pkg::TeamCount];
  logic [TeamW-1:0] order_ring [tgq_pkg::TeamCount];
  logic [tgq_pkg::TeamCount-1:0] team_waiting;
  // Free ring was never written before its first wrap: init flags by fill count.
  logic [SlotW:0]   free_fill;

  logic [SlotW-1:0] free_head;
  logic [SlotW:0]   used_count;
  logic [TeamW-1:0] order_read_ptr, order_write_ptr;
  logic [TeamW:0]   order_count;
  logic [IdW-1:0]   clear_idx;

  tgq_pkg::request_t req;
  logic [TeamW-1:0] t_reg;      // team of the request, or the head team for a dequeue
  logic [SlotW-1:0] free_rd;    // free ring entry
  logic [SlotW-1:0] head_rd, tail_rd;
  logic [IdW-1:0]   val_rd;
  logic [SlotW-1:0] next_rd;

  assign stat.clear_last = (clear_idx == IdW'(tgq_pkg::IdSpace - 1));

  always_ff @(posedge clk) begin
    if (rst) clear_idx <= '0;
    else if (cmd.clear) clear_idx <= clear_idx + 1'b1;
  end

  // Memory accesses.
  logic [SlotW-1:0] rel_pos;
  logic [SlotW-1:0] free_pos;
  assign free_pos = free_head;
  assign rel_pos = free_head - used_count[SlotW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clear) team_of_element[clear_idx] <= '0;
    else if (cmd.commit && req.kind == tgq_pkg::KIND_BIND)
      team_of_element[req.element_id] <= req.team;
    if (cmd.rd1) begin
      t_reg   <= (req.kind == tgq_pkg::KIND_DEQ) ? order_ring[order_read_ptr]
                                                  : team_of_element[req.element_id];
      free_rd <= free_slots[free_pos];
    end
    if (cmd.rd2) begin
      head_rd <= team_head_slot[t_reg];
      tail_rd <= team_tail_slot[t_reg];
    end
  end

  // The request is held from acceptance until its write-back.
  always_ff @(posedge clk) begin
    if (cmd.load) req <= request;
  end

  logic enq_ok, deq_ok, free_from_ring;
  logic [SlotW-1:0] s_new;
  assign enq_ok = (req.kind == tgq_pkg::KIND_ENQ) && !used_count[SlotW];
  assign deq_ok = (req.kind == tgq_pkg::KIND_DEQ) && (order_count != '0);
  assign free_from_ring = (free_fill > {1'b0, free_head}) || free_fill[SlotW];
  assign s_new = free_from_ring ? free_rd : free_head;

  // The head slot's value and link are read once the head pointer is
  // registered.
  always_ff @(posedge clk) begin
    if (cmd.rd3) begin
      val_rd  <= slot_value[head_rd];
      next_rd <= slot_next[head_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && enq_ok) begin
      slot_value[s_new] <= req.element_id;
      if (team_waiting[t_reg]) slot_next[tail_rd] <= s_new;
    end
    if (cmd.commit && deq_ok)
      free_slots[rel_pos] <= head_rd;
    if (cmd.commit && enq_ok) begin
      team_tail_slot[t_reg] <= s_new;
      if (!team_waiting[t_reg]) begin
        team_head_slot[t_reg] <= s_new;
        order_ring[order_write_ptr] <= t_reg;
      end
    end else if (cmd.commit && deq_ok && head_rd != tail_rd) begin
      team_head_slot[t_reg] <= next_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      team_waiting <= '0;
      free_head <= '0;
      used_count <= '0;
      order_read_ptr <= '0;
      order_write_ptr <= '0;
      order_count <= '0;
      free_fill <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cmd.commit && enq_ok) begin
        free_head <= free_head + 1'b1;
        used_count <= used_count + 1'b1;
        if (!team_waiting[t_reg]) begin
          team_waiting[t_reg] <= 1'b1;
          order_write_ptr <= order_write_ptr + 1'b1;
          order_count <= order_count + 1'b1;
        end
      end
      if (cmd.commit && deq_ok) begin
        used_count <= used_count - 1'b1;
        if (!free_fill[SlotW] && ({1'b0, rel_pos} >= free_fill))
          free_fill <= {1'b0, rel_pos} + 1'b1;
        if (head_rd == tail_rd) begin
          team_waiting[t_reg] <= 1'b0;
          order_read_ptr <= order_read_ptr + 1'b1;
          order_count <= order_count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.element_id_out <= deq_ok ? val_rd : '0;
      case (req.kind)
        tgq_pkg::KIND_ENQ: result.status <= enq_ok ? tgq_pkg::ST_DONE : tgq_pkg::ST_FULL;
        tgq_pkg::KIND_DEQ: result.status <= deq_ok ? tgq_pkg::ST_ELEM : tgq_pkg::ST_EMPTY;
        default:           result.status <= tgq_pkg::ST_DONE;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= (SlotW+1)'(tgq_pkg::Capacity)) else $error("used_count overflow");
  a_order_bound: assert property (@(posedge clk) disable iff (rst)
    order_count <= (TeamW+1)'(tgq_pkg::TeamCount)) else $error("order_count overflow");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held");
endmodule

// ----- sim/tb_team_grouped_queue.sv -----
// Testbench for the team grouped queue: directed table, then random requests.
// Checks every result against a behavioral team queue; depends on tgq_pkg and RTL.
module tb_team_grouped_queue;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  tgq_pkg::request_t request = '0;
  logic              busy, done;
  tgq_pkg::result_t  result;

  team_grouped_queue dut (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .result(result)
  );

  always #5 clk = ~clk;

  // Behavioral team queue: one queue of ids per team plus the order of teams.
  logic [tgq_pkg::TeamW-1:0] member_team [tgq_pkg::IdSpace];
  logic [tgq_pkg::IdW-1:0]   team_run [tgq_pkg::TeamCount][$];
  logic [tgq_pkg::TeamW-1:0] team_order [$];
  int                        stored;

  tgq_pkg::result_t result_fifo [$];
  int      errors = 0;
  int      accepted = 0;
  int      results_seen = 0;
  int      idle_cycles = 0;
  int      send_gap_pct = 0;

  function automatic tgq_pkg::result_t predict_queue(tgq_pkg::request_t rq);
    tgq_pkg::result_t r;
    logic [tgq_pkg::TeamW-1:0] t;
    r = '0;
    case (tgq_pkg::kind_t'(rq.kind))
      tgq_pkg::KIND_BIND: member_team[rq.element_id] = rq.team;
      tgq_pkg::KIND_ENQ: begin
        if (stored >= tgq_pkg::Capacity) begin
          r.status = tgq_pkg::ST_FULL;
        end else begin
          t = member_team[rq.element_id];
          // A team with nothing queued joins the tail of the team order.
          if (team_run[t].size() == 0) team_order.insert(team_order.size(), t);
          team_run[t].insert(team_run[t].size(), rq.element_id);
          stored++;
        end
      end
      tgq_pkg::KIND_DEQ: begin
        if (team_order.size() == 0) begin
          r.status = tgq_pkg::ST_EMPTY;
        end else begin
          t = team_order[0];
          r.status = tgq_pkg::ST_ELEM;
          r.element_id_out = team_run[t].pop_front();
          if (team_run[t].size() == 0) void'(team_order.pop_front());
          stored--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Results are sampled at the rising edge that ends their strobe cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (result_fifo.size() == 0) begin
        report_mismatch("unexpected result status", result.status, -1);
      end else begin
        tgq_pkg::result_t want;
        want = result_fifo.pop_front();
        if (result.status !== want.status)
          report_mismatch("status", result.status, want.status);
        if (result.element_id_out !== want.element_id_out)
          report_mismatch("element_id_out", result.element_id_out, want.element_id_out);
      end
    end
  end

  // Watchdog: no request or result for too long ends the run. The limit
  // is well above the length of the clearing pass after reset.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  typedef struct {
    tgq_pkg::request_t rq;
    bit                has_fixed;
    tgq_pkg::result_t  fixed;
  } stim_row_t;

  stim_row_t directed [$];

  function automatic void add_row(tgq_pkg::kind_t k, int id, int tm, bit fx,
                                  tgq_pkg::status_t st, int val);
    stim_row_t s;
    s.rq.kind = k;
    s.rq.element_id = id[tgq_pkg::IdW-1:0];
    s.rq.team = tm[tgq_pkg::TeamW-1:0];
    s.has_fixed = fx;
    s.fixed.status = st;
    s.fixed.element_id_out = val[tgq_pkg::IdW-1:0];
    directed.insert(directed.size(), s);
  endfunction

  // Sends one request and returns at the falling edge after it is taken.
  // Start only drops in a sender gap or at the end of the run, so it gets
  // at most one assignment per falling edge.
  task automatic send_request(tgq_pkg::request_t rq, bit has_fixed,
                              tgq_pkg::result_t fixed);
    tgq_pkg::result_t want;
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = predict_queue(rq);
    if (has_fixed && want !== fixed) report_mismatch("directed table row", fixed, want);
    result_fifo.insert(result_fifo.size(), want);
    accepted++;
    @(negedge clk);
  endtask

  function automatic tgq_pkg::request_t random_request(int id_hi, int team_hi);
    tgq_pkg::request_t rq;
    int p;
    int id;
    int tm;
    p = $urandom_range(99);
    rq.kind = p < 15 ? tgq_pkg::KIND_BIND : p < 58 ? tgq_pkg::KIND_ENQ :
              p < 97 ? tgq_pkg::KIND_DEQ : tgq_pkg::KIND_NONE;
    // Mostly a few ids and teams so runs merge; sometimes the full range.
    id = $urandom_range(3) == 0 ? $urandom_range(tgq_pkg::IdSpace - 1)
                                : $urandom_range(id_hi);
    tm = $urandom_range(3) == 0 ? $urandom_range(tgq_pkg::TeamCount - 1)
                                : $urandom_range(team_hi);
    rq.element_id = id[tgq_pkg::IdW-1:0];
    rq.team = tm[tgq_pkg::TeamW-1:0];
    return rq;
  endfunction

  initial begin
    tgq_pkg::result_t none;
    none = '0;
    stored = 0;
    foreach (member_team[i]) member_team[i] = '0;

    // Expected values are typed in where obvious; others come from the predictor.
    add_row(tgq_pkg::KIND_DEQ,  0,    0,   1, tgq_pkg::ST_EMPTY, 0);
    add_row(tgq_pkg::KIND_NONE, 1023, 255, 1, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_ENQ,  1023, 0,   1, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_BIND, 5,    255, 1, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_BIND, 6,    255, 1, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_BIND, 1023, 255, 1, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_ENQ,  5,    0,   1, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_ENQ,  0,    0,   0, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_ENQ,  6,    0,   0, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_ENQ,  1023, 0,   0, tgq_pkg::ST_DONE,  0);
    // The rebound id stays in the team 0 run it already joined.
    add_row(tgq_pkg::KIND_DEQ,  0,    0,   1, tgq_pkg::ST_ELEM,  1023);
    add_row(tgq_pkg::KIND_DEQ,  0,    0,   0, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_DEQ,  0,    0,   0, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_DEQ,  0,    0,   0, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_DEQ,  0,    0,   0, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_DEQ,  0,    0,   1, tgq_pkg::ST_EMPTY, 0);
    add_row(tgq_pkg::KIND_BIND, 682,  170, 0, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_BIND, 341,  85,  0, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_ENQ,  341,  0,   0, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_ENQ,  682,  0,   0, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_DEQ,  0,    0,   0, tgq_pkg::ST_DONE,  0);
    add_row(tgq_pkg::KIND_DEQ,  0,    0,   0, tgq_pkg::ST_DONE,  0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_request(directed[i].rq, directed[i].has_fixed, directed[i].fixed);

    // Random phases with varying sender gaps.
    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct = ph == 1 ? 61 : ph == 2 ? 25 : 0;
      for (int n = 0; n < 180; n++)
        send_request(random_request(ph == 3 ? 31 : 15, ph == 3 ? 7 : 3), 0, none);
    end
    start <= 1'b0;

    while (result_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (result_fifo.size() != 0)
      report_mismatch("results still owed", result_fifo.size(), 0);
    $display("Ran %0d requests with %0d results: binds, enqueues into shared team runs,",
             accepted, results_seen);
    $display("rebinding of queued ids, empty dequeues, unused kinds and sender gaps.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/tgq_pkg.sv
hw/rtl/tgq_ctrl.sv
hw/rtl/tgq_datapath.sv
hw/rtl/team_grouped_queue.sv
sim/tb_team_grouped_queue.sv
